>>> rtl/core/rtph264_pkg.sv
// ----------------------------------------------------------------------------
// RTP H.264 depacketizer package
// Shared types and constants for the depacketizer front end, job queue and
// byte-stream emitter.
// ----------------------------------------------------------------------------
package rtph264_pkg;

    localparam int LEN_W                    = 17;
    localparam int DEFAULT_MAX_PACKET_BYTES = 65536;
    localparam int DEFAULT_QUEUE_DEPTH      = 4;

    localparam logic [6:0] RTP_FIXED_HEADER_BYTES = 7'd12;
    localparam logic [4:0] NAL_TYPE_STAP_A        = 5'd24;
    localparam logic [4:0] NAL_TYPE_FU_A          = 5'd28;

    // Start code 00 00 00 01 followed by the NAL byte: five results
    localparam logic [2:0] START_LAST_PHASE = 3'd4;
    localparam logic [2:0] START_ONE_PHASE  = 3'd3;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] packet_length;
    } pkt_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       header_error;
        logic       last_of_run;
    } stream_item_t;

    typedef enum logic [1:0] {
        JOB_STATUS     = 2'd0,
        JOB_BYTE       = 2'd1,
        JOB_START_BYTE = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] data;
    } job_t;

endpackage

>>> rtl/core/rtph264_front.sv
// ----------------------------------------------------------------------------
// RTP H.264 depacketizer front end
// Tracks the packet position, skips the RTP header, classifies the payload
// and turns each packet byte into at most one output job.
// ----------------------------------------------------------------------------
module rtph264_front
    import rtph264_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = DEFAULT_MAX_PACKET_BYTES
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  pkt_item_t item,
    output logic      job_valid,
    output job_t      job
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PACKET_BYTES);

    typedef enum logic [5:0] {
        KIND_NAL_HDR = 6'b000001,
        KIND_SINGLE  = 6'b000010,
        KIND_STAP    = 6'b000100,
        KIND_FU_HDR  = 6'b001000,
        KIND_FU_DATA = 6'b010000,
        KIND_DROP    = 6'b100000
    } kind_t;

    typedef enum logic [3:0] {
        AGG_LEN_HI = 4'b0001,
        AGG_LEN_LO = 4'b0010,
        AGG_FIRST  = 4'b0100,
        AGG_BODY   = 4'b1000
    } agg_t;

    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [6:0]       hdr_bytes_reg, hdr_bytes_next;
    kind_t            kind_reg, kind_next;
    logic [2:0]       f_nri_reg, f_nri_next;
    agg_t             agg_reg, agg_next;
    logic [7:0]       len_hi_reg, len_hi_next;
    logic [15:0]      unit_left_reg, unit_left_next;

    logic [LEN_W-1:0] len_eff;
    logic [LEN_W:0]   pos_inc;
    logic [LEN_W:0]   bytes_left;
    logic [15:0]      unit_len;
    logic [15:0]      unit_dec;
    logic [6:0]       hdr_calc;
    logic [7:0]       b;

    always_comb
    begin
        b        = item.data_byte;
        len_eff  = item.packet_length;
        if (len_eff == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (len_eff > MAX_LEN)
        begin
            len_eff = MAX_LEN;
        end
        pos_inc    = {1'b0, pos_reg} + (LEN_W+1)'(1);
        bytes_left = ({1'b0, len_eff} > pos_inc) ? ({1'b0, len_eff} - pos_inc) : '0;
        unit_len   = {len_hi_reg, b};
        unit_dec   = unit_left_reg - 16'd1;
        hdr_calc   = RTP_FIXED_HEADER_BYTES + 7'({b[3:0], 2'b00});
    end

    always_comb
    begin
        pos_next       = pos_reg;
        hdr_bytes_next = hdr_bytes_reg;
        kind_next      = kind_reg;
        f_nri_next     = f_nri_reg;
        agg_next       = agg_reg;
        len_hi_next    = len_hi_reg;
        unit_left_next = unit_left_reg;
        job_valid      = 1'b0;
        job.kind       = JOB_BYTE;
        job.data       = b;

        if (take)
        begin
            if (pos_reg == '0)
            begin
                kind_next      = KIND_NAL_HDR;
                agg_next       = AGG_LEN_HI;
                hdr_bytes_next = hdr_calc;
                if (len_eff < LEN_W'(hdr_calc))
                begin
                    job_valid = 1'b1;
                    job.kind  = JOB_STATUS;
                    job.data  = 8'd0;
                    kind_next = KIND_DROP;
                end
            end
            else if (pos_reg >= LEN_W'(hdr_bytes_reg))
            begin
                unique case (kind_reg)
                    KIND_NAL_HDR:
                    begin
                        f_nri_next = b[7:5];
                        if (b[4:0] < NAL_TYPE_STAP_A)
                        begin
                            job_valid = 1'b1;
                            job.kind  = JOB_START_BYTE;
                            kind_next = KIND_SINGLE;
                        end
                        else if (b[4:0] == NAL_TYPE_STAP_A)
                        begin
                            kind_next = KIND_STAP;
                            agg_next  = AGG_LEN_HI;
                        end
                        else if (b[4:0] == NAL_TYPE_FU_A)
                        begin
                            kind_next = KIND_FU_HDR;
                        end
                        else
                        begin
                            kind_next = KIND_DROP;
                        end
                    end
                    KIND_SINGLE, KIND_FU_DATA:
                    begin
                        job_valid = 1'b1;
                    end
                    KIND_FU_HDR:
                    begin
                        // Rebuild the NAL header from indicator F/NRI and FU type
                        if (b[7])
                        begin
                            job_valid = 1'b1;
                            job.kind  = JOB_START_BYTE;
                            job.data  = {f_nri_reg, b[4:0]};
                        end
                        kind_next = KIND_FU_DATA;
                    end
                    KIND_STAP:
                    begin
                        unique case (agg_reg)
                            AGG_LEN_HI:
                            begin
                                len_hi_next = b;
                                agg_next    = AGG_LEN_LO;
                            end
                            AGG_LEN_LO:
                            begin
                                if (unit_len == 16'd0)
                                begin
                                    agg_next = AGG_LEN_HI;
                                end
                                else if ({2'b00, unit_len} > bytes_left)
                                begin
                                    kind_next = KIND_DROP;
                                end
                                else
                                begin
                                    unit_left_next = unit_len;
                                    agg_next       = AGG_FIRST;
                                end
                            end
                            AGG_FIRST, AGG_BODY:
                            begin
                                job_valid      = 1'b1;
                                job.kind       = (agg_reg == AGG_FIRST) ? JOB_START_BYTE
                                                                        : JOB_BYTE;
                                unit_left_next = unit_dec;
                                agg_next       = (unit_dec == 16'd0) ? AGG_LEN_HI : AGG_BODY;
                            end
                            default:
                            begin
                                agg_next = AGG_LEN_HI;
                            end
                        endcase
                    end
                    KIND_DROP:
                    begin
                        kind_next = KIND_DROP;
                    end
                    default:
                    begin
                        kind_next = KIND_DROP;
                    end
                endcase
            end

            // Wrap at the last byte of the packet
            if (pos_inc >= {1'b0, len_eff})
            begin
                pos_next       = '0;
                kind_next      = KIND_NAL_HDR;
                agg_next       = AGG_LEN_HI;
                unit_left_next = 16'd0;
            end
            else
            begin
                pos_next = pos_inc[LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            hdr_bytes_reg <= RTP_FIXED_HEADER_BYTES;
            kind_reg      <= KIND_NAL_HDR;
            f_nri_reg     <= 3'd0;
            agg_reg       <= AGG_LEN_HI;
            len_hi_reg    <= 8'd0;
            unit_left_reg <= 16'd0;
        end
        else
        begin
            pos_reg       <= pos_next;
            hdr_bytes_reg <= hdr_bytes_next;
            kind_reg      <= kind_next;
            f_nri_reg     <= f_nri_next;
            agg_reg       <= agg_next;
            len_hi_reg    <= len_hi_next;
            unit_left_reg <= unit_left_next;
        end
    end

endmodule

>>> rtl/core/rtph264_queue.sv
// ----------------------------------------------------------------------------
// RTP H.264 depacketizer job queue
// Short first-in first-out queue of jobs between front end and emitter.
// ----------------------------------------------------------------------------
module rtph264_queue
    import rtph264_pkg::*;
#(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic empty,
    output logic full,
    output job_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/rtph264_back.sv
// ----------------------------------------------------------------------------
// RTP H.264 depacketizer emitter
// Expands queued jobs into output results, inserting the Annex B start code,
// and holds them in the output register.
// ----------------------------------------------------------------------------
module rtph264_back
    import rtph264_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         head_valid,
    input  job_t         head,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_stall,
    output stream_item_t out_item
);

    logic [2:0]   phase_reg, phase_next;
    logic         out_valid_reg, out_valid_next;
    stream_item_t out_item_reg, out_item_next;
    logic         load;
    logic         job_done;

    assign load      = head_valid && (!out_valid_reg || !out_stall);
    assign pop       = load && job_done;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        job_done      = 1'b1;
        out_item_next = out_item_reg;
        phase_next    = phase_reg;

        unique case (head.kind)
            JOB_STATUS:
            begin
                out_item_next = '{out_byte: 8'd0, has_byte: 1'b0,
                                  header_error: 1'b1, last_of_run: 1'b1};
            end
            JOB_START_BYTE:
            begin
                job_done = (phase_reg == START_LAST_PHASE);
                out_item_next.has_byte     = 1'b1;
                out_item_next.header_error = 1'b0;
                out_item_next.last_of_run  = job_done;
                if (job_done)
                begin
                    out_item_next.out_byte = head.data;
                end
                else if (phase_reg == START_ONE_PHASE)
                begin
                    out_item_next.out_byte = 8'd1;
                end
                else
                begin
                    out_item_next.out_byte = 8'd0;
                end
            end
            default:
            begin
                out_item_next = '{out_byte: head.data, has_byte: 1'b1,
                                  header_error: 1'b0, last_of_run: 1'b1};
            end
        endcase

        if (load)
        begin
            phase_next = job_done ? 3'd0 : phase_reg + 3'd1;
        end
        else
        begin
            out_item_next = out_item_reg;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/core/rtp_h264_depacketizer.sv
// ----------------------------------------------------------------------------
// RTP H.264 depacketizer
// Turns the bytes of RTP packets carrying H.264 (single NAL, STAP-A, FU-A)
// into an Annex B byte stream.
// ----------------------------------------------------------------------------
// Packet bytes are taken one per cycle on the pkt channel while the job queue
// has room; each byte becomes at most one job that the emitter expands into
// one result, or five when a 00 00 00 01 start code goes ahead of it. The
// emitter's output register delivers one result per cycle unless stream_stall
// is high, so bytes flow at one per cycle except where start codes are added;
// their extra results are absorbed by the QUEUE_DEPTH-entry job queue and then
// by holding pkt_stall. A byte's job is registered in the queue, then its first
// result in the output register that drives the stream channel. Packets shorter
// than their RTP header give one status result with header_error set.
module rtp_h264_depacketizer
    import rtph264_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = DEFAULT_MAX_PACKET_BYTES,
    parameter int QUEUE_DEPTH      = DEFAULT_QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pkt_valid,
    output logic         pkt_stall,
    input  pkt_item_t    pkt_data,
    output logic         stream_valid,
    input  logic         stream_stall,
    output stream_item_t stream_data
);

    logic job_valid;
    job_t job;
    logic queue_empty;
    logic queue_full;
    job_t head;
    logic pop;
    logic take;

    assign pkt_stall = queue_full;
    assign take      = pkt_valid && !queue_full;

    rtph264_front #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (pkt_data),
        .job_valid (job_valid),
        .job       (job)
    );

    rtph264_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_valid),
        .push_job (job),
        .pop      (pop),
        .empty    (queue_empty),
        .full     (queue_full),
        .head     (head)
    );

    rtph264_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!queue_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (stream_valid),
        .out_stall  (stream_stall),
        .out_item   (stream_data)
    );

    // A status transaction carries no byte and closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (stream_valid && !stream_data.has_byte) |->
            (stream_data.out_byte == 8'd0 && stream_data.header_error &&
             stream_data.last_of_run))
        else $error("malformed status result");

    // Results inside a start-code run never carry an error
    assert property (@(posedge clk) disable iff (!rst_n)
        (stream_valid && !stream_stall && !stream_data.last_of_run) |=>
            (!stream_data.header_error && stream_data.has_byte))
        else $error("error flag inside a start-code run");

    // Input is held back only when the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        queue_empty |-> !pkt_stall)
        else $error("input stalled with an empty job queue");

endmodule
